>>> rtl/cfup_pkg.sv
// ----------------------------------------------------------------------------
// cfup_pkg
// Shared widths, constants, stage payload types and the divider step for the
// cube face UV projection core.
// ----------------------------------------------------------------------------
package cfup_pkg;

  // Field widths
  localparam int unsigned DIR_W    = 16;  // signed direction component
  localparam int unsigned MAG_W    = 16;  // major axis magnitude, 0..32768
  localparam int unsigned NUM_W    = 17;  // signed numerator, -32768..32768
  localparam int unsigned TEX_W    = 17;  // unsigned Q0.16 coordinate, 0..65536
  localparam int unsigned REM_W    = 15;  // partial remainder, always below m
  localparam int unsigned LO_W     = 2;   // dividend bits still to be fed in
  localparam int unsigned QUO_BITS = 17;  // quotient bits produced per lane

  // Centre of the face, returned for a zero vector
  localparam logic [TEX_W-1:0] HALF_SCALE = TEX_W'(32768);

  // Default number of divider steps in one pipeline stage
  localparam int unsigned STEPS_PER_STAGE_DEF = 3;

  // One lane of the restoring divider
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [TEX_W-1:0] quo;
    logic [LO_W-1:0]  lo;
  } div_lane_t;

  // Payload carried down the divider pipeline
  typedef struct packed {
    div_lane_t        u;
    div_lane_t        v;
    logic [MAG_W-1:0] mag;
    logic             zero;
  } div_t;

  // One restoring step: bring in the next dividend bit, trial subtract.
  function automatic div_lane_t div_step(div_lane_t l, logic [MAG_W-1:0] m);
    logic [MAG_W-1:0] r2;
    div_lane_t        o;
    r2    = {l.rem, l.lo[LO_W-1]};
    o     = l;
    o.lo  = {l.lo[LO_W-2:0], 1'b0};
    o.quo = {l.quo[TEX_W-2:0], 1'b0};
    if (r2 >= m) begin
      o.rem    = REM_W'(r2 - m);
      o.quo[0] = 1'b1;
    end else begin
      o.rem = r2[REM_W-1:0];
    end
    return o;
  endfunction

endpackage

>>> rtl/cfup_front.sv
// ----------------------------------------------------------------------------
// cfup_front
// Two pipeline stages: major axis selection with face numerators, then the
// offset sums that seed both divider lanes.
// ----------------------------------------------------------------------------
module cfup_front
  import cfup_pkg::*;
(
  input  logic                    clk_i,
  input  logic [1:0]              en_i,
  input  logic signed [DIR_W-1:0] dir_x_i,
  input  logic signed [DIR_W-1:0] dir_y_i,
  input  logic signed [DIR_W-1:0] dir_z_i,
  output div_t                    q_o
);

  logic signed [NUM_W-1:0] xs, ys, zs;
  logic [MAG_W-1:0]        ax, ay, az;
  logic [MAG_W-1:0]        mag_d, mag_q;
  logic signed [NUM_W-1:0] nu_d, nu_q, nv_d, nv_q;
  logic [NUM_W-1:0]        su, sv;
  div_t                    div_d, div_q;

  // Widen and take magnitudes; the most negative value stays exact
  assign xs = NUM_W'(dir_x_i);
  assign ys = NUM_W'(dir_y_i);
  assign zs = NUM_W'(dir_z_i);
  assign ax = dir_x_i[DIR_W-1] ? MAG_W'(-xs) : MAG_W'(xs);
  assign ay = dir_y_i[DIR_W-1] ? MAG_W'(-ys) : MAG_W'(ys);
  assign az = dir_z_i[DIR_W-1] ? MAG_W'(-zs) : MAG_W'(zs);

  // Pick the face: z wins ties over y, y over x
  always_comb begin
    if (az >= ax && az >= ay) begin
      mag_d = az;
      nu_d  = dir_z_i[DIR_W-1] ? -xs : xs;
      nv_d  = ys;
    end else if (ay >= ax && ay >= az) begin
      mag_d = ay;
      nu_d  = dir_y_i[DIR_W-1] ? xs : -xs;
      nv_d  = zs;
    end else begin
      mag_d = ax;
      nu_d  = dir_x_i[DIR_W-1] ? zs : -zs;
      nv_d  = ys;
    end
  end

  // Hold the face selection
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mag_q <= mag_d;
      nu_q  <= nu_d;
      nv_q  <= nv_d;
    end
  end

  // Offset numerators into 0..2m and seed the dividers; the sum never
  // leaves 0..65536, so it wraps back into range at this width
  assign su = NUM_W'(nu_q) + NUM_W'(mag_q);
  assign sv = NUM_W'(nv_q) + NUM_W'(mag_q);

  always_comb begin
    div_d.u.rem = su[NUM_W-1:LO_W];
    div_d.u.lo  = su[LO_W-1:0];
    div_d.u.quo = '0;
    div_d.v.rem = sv[NUM_W-1:LO_W];
    div_d.v.lo  = sv[LO_W-1:0];
    div_d.v.quo = '0;
    div_d.mag   = mag_q;
    div_d.zero  = (mag_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      div_q <= div_d;
    end
  end

  assign q_o = div_q;

endmodule

>>> rtl/cfup_div_stage.sv
// ----------------------------------------------------------------------------
// cfup_div_stage
// One divider pipeline stage: a few restoring steps on both lanes, then a
// register.
// ----------------------------------------------------------------------------
module cfup_div_stage
  import cfup_pkg::*;
#(
  parameter int unsigned STEPS = STEPS_PER_STAGE_DEF
) (
  input  logic clk_i,
  input  logic en_i,
  input  div_t d_i,
  output div_t q_o
);

  div_t step_d, step_q;

  // Run the restoring steps of this stage
  always_comb begin
    step_d = d_i;
    for (int unsigned j = 0; j < STEPS; j++) begin
      step_d.u = div_step(step_d.u, step_d.mag);
      step_d.v = div_step(step_d.v, step_d.mag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q <= step_d;
    end
  end

  assign q_o = step_q;

endmodule

>>> rtl/cube_face_uv_projection_core.sv
// ----------------------------------------------------------------------------
// cube_face_uv_projection_core
// Projects a signed direction onto its cube face and returns face UV
// coordinates in unsigned Q0.16.
// ----------------------------------------------------------------------------
// Takes one direction transaction per clock while in_stall_o is low and
// returns one result per transaction, in order. Two stages pick the face
// and form the offset numerators, then a pipelined restoring divider works
// out 17 quotient bits per coordinate, STEPS_PER_STAGE bits in each stage
// but the last, which takes whatever remain. Valid bits travel with the data
// and each stage fills whenever it is empty or its successor moves, so
// bubbles collapse and a stalled output holds its result while earlier
// stages keep filling. An all-zero direction returns the face centre
// (32768, 32768) with zero_vector set.
// ----------------------------------------------------------------------------
module cube_face_uv_projection_core
  import cfup_pkg::*;
#(
  parameter int unsigned STEPS_PER_STAGE = STEPS_PER_STAGE_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DIR_W-1:0] dir_x_i,
  input  logic signed [DIR_W-1:0] dir_y_i,
  input  logic signed [DIR_W-1:0] dir_z_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [TEX_W-1:0]        tex_u_o,
  output logic [TEX_W-1:0]        tex_v_o,
  output logic                    zero_vector_o
);

  localparam int unsigned DIV_STAGES = (QUO_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int unsigned N_STAGES   = DIV_STAGES + 2;

  logic [N_STAGES-1:0] valid_d, valid_q;
  logic [N_STAGES:0]   ready;
  div_t                stage_data [DIV_STAGES+1];
  div_t                last;

  // Stage k may load when it is empty or its contents move on
  assign ready[N_STAGES] = !out_stall_i;
  for (genvar k = 0; k < N_STAGES; k++) begin : g_ready
    assign ready[k] = !valid_q[k] || ready[k+1];
  end

  // Advance valid bits alongside the data
  always_comb begin
    valid_d[0] = ready[0] ? in_valid_i : valid_q[0];
    for (int unsigned k = 1; k < N_STAGES; k++) begin
      valid_d[k] = ready[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Face selection and divider seeding
  cfup_front u_front (
    .clk_i   (clk_i),
    .en_i    (ready[1:0]),
    .dir_x_i (dir_x_i),
    .dir_y_i (dir_y_i),
    .dir_z_i (dir_z_i),
    .q_o     (stage_data[0])
  );

  // Divider pipeline; the last stage takes whatever steps remain
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    localparam int unsigned STEPS_LEFT = QUO_BITS - k * STEPS_PER_STAGE;
    localparam int unsigned STEPS_HERE =
      (STEPS_LEFT < STEPS_PER_STAGE) ? STEPS_LEFT : STEPS_PER_STAGE;

    cfup_div_stage #(
      .STEPS (STEPS_HERE)
    ) u_stage (
      .clk_i (clk_i),
      .en_i  (ready[k+2]),
      .d_i   (stage_data[k]),
      .q_o   (stage_data[k+1])
    );
  end

  // Drive the result; a zero vector lands on the face centre
  assign last          = stage_data[DIV_STAGES];
  assign in_stall_o    = !ready[0];
  assign out_valid_o   = valid_q[N_STAGES-1];
  assign tex_u_o       = last.zero ? HALF_SCALE : last.u.quo;
  assign tex_v_o       = last.zero ? HALF_SCALE : last.v.quo;
  assign zero_vector_o = last.zero;

endmodule

>>> rtl/cfup_checker.sv
// ----------------------------------------------------------------------------
// cfup_checker
// Port-level checks for the cube face UV projection core, bound to the top
// level.
// ----------------------------------------------------------------------------
module cfup_checker
  import cfup_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [TEX_W-1:0]        tex_u_o,
  input logic [TEX_W-1:0]        tex_v_o,
  input logic                    zero_vector_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(tex_u_o) && $stable(tex_v_o) && $stable(zero_vector_o))
    else $error("stalled result payload changed");

  // An empty output stage means every stage can take data
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty output stage");

  // A zero vector lands on the face centre
  a_zero_centre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_vector_o |-> tex_u_o == HALF_SCALE && tex_v_o == HALF_SCALE)
    else $error("zero vector result off centre");

  // Coordinates stay within 0..1.0
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tex_u_o <= (HALF_SCALE << 1) && tex_v_o <= (HALF_SCALE << 1))
    else $error("coordinate out of range");

endmodule

bind cube_face_uv_projection_core cfup_checker u_cfup_checker (.*);
